// File: hw/rtl/ascd_pkg.sv
`timescale 1ns / 1ps

package ascd_pkg;

    localparam logic [7:0] CH_STD  = 8'h74;
    localparam logic [7:0] CH_EXT  = 8'h54;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;

    localparam logic [4:0] STD_ID_DIGITS = 5'd3;
    localparam logic [4:0] EXT_ID_DIGITS = 5'd8;
    localparam logic [3:0] STAMP_RESET   = 4'd4;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADLEN = 2'd1,
        ST_NOCR   = 2'd2,
        ST_BADHEX = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_IDENT = 6'b000010,
        PH_LEN   = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_STAMP = 6'b010000,
        PH_END   = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       bad;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_decode(logic [7:0] c);
        t_hex h;
        h.bad = 1'b0;
        h.nib = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.nib = 4'(c - CH_ZERO);
        end else if (c >= CH_UA && c <= CH_UF) begin
            h.nib = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF) begin
            h.nib = 4'(c - CH_LA + 8'd10);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

// File: hw/rtl/ascd_ifs.sv
`timescale 1ns / 1ps

interface ascd_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;

    modport source (output valid, output in_char, input ready);
    modport sink (input valid, input in_char, output ready);
endinterface

interface ascd_frame_if;
    logic        valid;
    logic        ready;
    logic        frame_extended;
    logic [31:0] frame_ident;
    logic [3:0]  byte_count;
    logic [63:0] payload;
    logic [1:0]  status;

    modport source (output valid, output frame_extended, output frame_ident,
                    output byte_count, output payload, output status, input ready);
    modport sink (input valid, input frame_extended, input frame_ident,
                  input byte_count, input payload, input status, output ready);
endinterface

// File: hw/rtl/ascd_in_stage.sv
`timescale 1ns / 1ps

module ascd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ascd_char_if.sink     i_char,
    ascd_char_if.source   o_char
);

    logic       r_vld;
    logic       n_vld;
    logic [7:0] r_char;

    assign i_char.ready   = !r_vld || o_char.ready;
    assign o_char.valid   = r_vld;
    assign o_char.in_char = r_char;

    always_comb begin
        n_vld = r_vld;
        if (o_char.ready) begin
            n_vld = 1'b0;
        end
        if (i_char.valid && i_char.ready) begin
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.in_char;
        end
    end

endmodule

// File: hw/rtl/ascd_parser.sv
`timescale 1ns / 1ps

module ascd_parser
    import ascd_pkg::*;
#(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_data,
    ascd_char_if.sink     i_char,
    ascd_frame_if.source  o_frame
);

    localparam int         AccW     = 8 * MAX_DATA_BYTES;
    localparam logic [7:0] MaxChar  = 8'(CH_ZERO + MAX_DATA_BYTES);
    localparam logic [3:0] MaxBytes = 4'(MAX_DATA_BYTES);

    logic [3:0]      r_stamp;
    t_phase          r_phase,  n_phase;
    logic [4:0]      r_count,  n_count;
    logic            r_kind,   n_kind;
    logic [31:0]     r_ident,  n_ident;
    logic [3:0]      r_len,    n_len;
    logic [AccW-1:0] r_acc,    n_acc;
    logic            r_herr,   n_herr;

    logic            r_out_vld, n_out_vld;
    logic            r_out_kind;
    logic [31:0]     r_out_ident;
    logic [3:0]      r_out_count;
    logic [63:0]     r_out_data;
    t_status         r_out_status;

    logic            w_adv;
    logic            w_emit;
    t_status         w_status;
    logic [3:0]      w_len;
    logic [63:0]     w_data;
    logic [4:0]      w_inc;
    t_hex            w_hex;
    logic [7:0]      w_c;

    assign w_adv = i_char.valid && (!r_out_vld || o_frame.ready);
    assign i_char.ready = !r_out_vld || o_frame.ready;

    assign w_c   = i_char.in_char;
    assign w_hex = hex_decode(w_c);
    assign w_inc = r_count + 5'd1;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_kind   = r_kind;
        n_ident  = r_ident;
        n_len    = r_len;
        n_acc    = r_acc;
        n_herr   = r_herr;
        w_emit   = 1'b0;
        w_status = ST_OK;
        case (r_phase)
            PH_HUNT: begin
                if (w_c == CH_STD || w_c == CH_EXT) begin
                    n_kind  = (w_c == CH_EXT);
                    n_ident = '0;
                    n_len   = '0;
                    n_acc   = '0;
                    n_herr  = 1'b0;
                    n_count = '0;
                    n_phase = PH_IDENT;
                end
            end
            PH_IDENT: begin
                n_ident = {r_ident[27:0], w_hex.nib};
                n_herr  = r_herr | w_hex.bad;
                n_count = w_inc;
                if (w_inc >= (r_kind ? EXT_ID_DIGITS : STD_ID_DIGITS)) begin
                    n_count = '0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (w_c >= CH_ZERO && w_c <= MaxChar) begin
                    n_len   = 4'(w_c - CH_ZERO);
                    n_count = '0;
                    if (n_len == 4'd0) begin
                        n_phase = (r_stamp == 4'd0) ? PH_END : PH_STAMP;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_len    = '0;
                    w_emit   = 1'b1;
                    w_status = ST_BADLEN;
                end
            end
            PH_DATA: begin
                n_acc   = {r_acc[AccW-5:0], w_hex.nib};
                n_herr  = r_herr | w_hex.bad;
                n_count = w_inc;
                if (w_inc >= {r_len, 1'b0}) begin
                    n_count = '0;
                    n_phase = (r_stamp == 4'd0) ? PH_END : PH_STAMP;
                end
            end
            PH_STAMP: begin
                n_count = w_inc;
                if (w_inc >= {1'b0, r_stamp}) begin
                    n_count = '0;
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                w_emit = 1'b1;
                if (w_c != CH_CR) begin
                    w_status = ST_NOCR;
                end else begin
                    w_status = r_herr ? ST_BADHEX : ST_OK;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                n_count = '0;
            end
        endcase
        if (w_emit) begin
            n_phase = PH_HUNT;
            n_count = '0;
        end
    end

    always_comb begin
        w_len  = (w_status == ST_BADLEN) ? 4'd0 : r_len;
        w_data = '0;
        if (w_len != 4'd0) begin
            w_data = 64'(r_acc) << (7'd64 - {w_len, 3'b000});
        end
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_frame.ready) begin
            n_out_vld = 1'b0;
        end
        if (w_adv && w_emit) begin
            n_out_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp   <= STAMP_RESET;
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_stamp <= i_cfg_data;
            end
            if (w_adv) begin
                r_phase <= n_phase;
                r_count <= n_count;
            end
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_kind  <= n_kind;
            r_ident <= n_ident;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_herr  <= n_herr;
        end
        if (w_adv && w_emit) begin
            r_out_kind   <= r_kind;
            r_out_ident  <= r_ident;
            r_out_count  <= w_len;
            r_out_data   <= w_data;
            r_out_status <= w_status;
        end
    end

    assign o_frame.valid          = r_out_vld;
    assign o_frame.frame_extended = r_out_kind;
    assign o_frame.frame_ident    = r_out_ident;
    assign o_frame.byte_count     = r_out_count;
    assign o_frame.payload        = r_out_data;
    assign o_frame.status         = r_out_status;

    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |-> (r_phase == PH_END || r_phase == PH_LEN))
        else $error("result raised outside length or end phase");

    a_emit_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit) |=> (r_phase == PH_HUNT && r_count == 5'd0))
        else $error("parser did not return to hunting after a result");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_count <= MaxBytes))
        else $error("byte count above maximum");

    a_badlen_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status == ST_BADLEN) |->
            (r_out_count == 4'd0 && r_out_data == 64'd0))
        else $error("bad length result carries data");

    a_ident_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDENT) |-> (r_count < EXT_ID_DIGITS))
        else $error("identifier digit count overrun");

endmodule

// File: hw/rtl/ascii_can_frame_deframer.sv
`timescale 1ns / 1ps

// Recovers CAN frames from the character stream of a serial-line CAN adapter
// ('t' standard, 'T' extended, hex identifier, length digit, hex data,
// stamp_chars skipped timestamp characters, carriage return). One character
// is taken per clock cycle, sustained while no result is stalled; the character
// that ends the frame passes the input register, then the parser, and its
// result is registered in the result register. A stalled result holds and lets
// one more character into the input register before i_char.ready drops.
// Write stamp_chars through i_cfg_we/i_cfg_data only while no frame is open.
module ascii_can_frame_deframer #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_data,
    ascd_char_if.sink     i_char,
    ascd_frame_if.source  o_frame
);

    ascd_char_if u_char_q ();

    ascd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .o_char  (u_char_q.source)
    );

    ascd_parser #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_char     (u_char_q.sink),
        .o_frame    (o_frame)
    );

endmodule

// File: bench/ascii_can_frame_deframer_test.sv
`timescale 1ns / 1ps

module ascii_can_frame_deframer_test;

    import ascd_pkg::*;

    localparam int MAX_BYTES       = 8;
    localparam int PHASE_ITEMS     = 175;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int CYCLE_LIMIT     = 200000;

    typedef struct packed {
        logic        ext;
        logic [31:0] ident;
        logic [3:0]  count;
        logic [63:0] payload;
        t_status     status;
    } frame_t;

    typedef struct {
        string  text;
        bit     typed;
        frame_t want;
    } script_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_data;

    ascd_char_if  char_bus ();
    ascd_frame_if frame_bus ();

    ascii_can_frame_deframer #(.MAX_DATA_BYTES(MAX_BYTES)) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_char     (char_bus),
        .o_frame    (frame_bus)
    );

    // Parser state mirrored from the character stream
    t_phase      prs_phase;
    logic [4:0]  digit_count;
    logic        frame_is_ext;
    logic [31:0] ident_shift;
    logic [3:0]  data_len;
    logic [63:0] data_shift;
    logic        saw_bad_hex;
    logic [3:0]  stamp_len;

    frame_t      pending_frames[$];
    int unsigned mismatches;
    int unsigned taken_chars;
    int unsigned cycle_count;
    bit          row_typed;
    bit          idle_on;
    bit          hold_off_req;
    logic [3:0]  stamp_plan [6];

    script_row_t script [13] = '{
        '{"x\377 9\015", 1'b0, '0},
        '{"t12300000\015", 1'b1, '{1'b0, 32'h123, 4'd0, 64'd0, ST_OK}},
        '{"TFFFFFFFF8FFFFFFFFFFFFFFFF9999\015", 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, ST_OK}},
        '{"T1fffffff80123456789abcdefTt\015\015\015", 1'b1,
          '{1'b1, 32'h1FFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF, ST_OK}},
        '{"t0001ABwxyz\015", 1'b1,
          '{1'b0, 32'h000, 4'd1, 64'hAB00_0000_0000_0000, ST_OK}},
        '{"t7FF9", 1'b1, '{1'b0, 32'h7FF, 4'd0, 64'd0, ST_BADLEN}},
        '{"tg12/", 1'b1, '{1'b0, 32'h012, 4'd0, 64'd0, ST_BADLEN}},
        '{"t1232zz11abcd\015", 1'b1,
          '{1'b0, 32'h123, 4'd2, 64'h0011_0000_0000_0000, ST_BADHEX}},
        '{"t1230abcdt", 1'b1, '{1'b0, 32'h123, 4'd0, 64'd0, ST_NOCR}},
        '{"tx230abcdT", 1'b1, '{1'b0, 32'h023, 4'd0, 64'd0, ST_NOCR}},
        '{"tT1t1Ab\015\015\015\015\015", 1'b0, '0},
        '{"T0123456720102abcd\015", 1'b0, '0},
        '{"t5A53c0FfEe1234\015", 1'b0, '0}
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
               (c >= CH_LA && c <= CH_LF);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (!is_hex_char(c)) begin
            saw_bad_hex = 1'b1;
            return 4'd0;
        end
        if (c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end else begin
            v = c - CH_LA + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic frame_t close_frame(input t_status st);
        frame_t f;
        f.ext     = frame_is_ext;
        f.ident   = ident_shift;
        f.count   = (st == ST_BADLEN) ? 4'd0 : data_len;
        f.payload = (f.count == 0) ? 64'd0 : data_shift << (64 - 8 * f.count);
        f.status  = st;
        prs_phase   = PH_HUNT;
        digit_count = '0;
        return f;
    endfunction

    function automatic void open_stamp();
        digit_count = '0;
        prs_phase   = (stamp_len == 0) ? PH_END : PH_STAMP;
    endfunction

    task automatic parse_char(input logic [7:0] c, output logic got, output frame_t f);
        got = 1'b0;
        f   = '0;
        case (prs_phase)
            PH_HUNT: begin
                if (c == CH_STD || c == CH_EXT) begin
                    frame_is_ext = (c == CH_EXT);
                    ident_shift  = '0;
                    data_len     = '0;
                    data_shift   = '0;
                    saw_bad_hex  = 1'b0;
                    digit_count  = '0;
                    prs_phase    = PH_IDENT;
                end
            end
            PH_IDENT: begin
                ident_shift = {ident_shift[27:0], hex_value(c)};
                digit_count++;
                if (digit_count >= (frame_is_ext ? EXT_ID_DIGITS : STD_ID_DIGITS)) begin
                    digit_count = '0;
                    prs_phase   = PH_LEN;
                end
            end
            PH_LEN: begin
                if (c >= CH_ZERO && c <= CH_ZERO + MAX_BYTES) begin
                    data_len    = c[3:0];
                    digit_count = '0;
                    if (data_len == 0) begin
                        open_stamp();
                    end else begin
                        prs_phase = PH_DATA;
                    end
                end else begin
                    data_len = '0;
                    f   = close_frame(ST_BADLEN);
                    got = 1'b1;
                end
            end
            PH_DATA: begin
                data_shift = {data_shift[59:0], hex_value(c)};
                digit_count++;
                if (digit_count >= 2 * data_len) begin
                    open_stamp();
                end
            end
            PH_STAMP: begin
                digit_count++;
                if (digit_count >= stamp_len) begin
                    digit_count = '0;
                    prs_phase   = PH_END;
                end
            end
            PH_END: begin
                if (c != CH_CR) begin
                    f = close_frame(ST_NOCR);
                end else if (saw_bad_hex) begin
                    f = close_frame(ST_BADHEX);
                end else begin
                    f = close_frame(ST_OK);
                end
                got = 1'b1;
            end
            default: begin
                prs_phase   = PH_HUNT;
                digit_count = '0;
            end
        endcase
    endtask

    // Enter at a falling edge; return at the falling edge after the word is taken
    task automatic send_char(input logic [7:0] c);
        logic   got;
        frame_t f;
        if (idle_on && $urandom_range(0, 99) < 4) begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        char_bus.valid   <= 1'b1;
        char_bus.in_char <= c;
        do @(posedge clk); while (!char_bus.ready);
        @(negedge clk);
        if (!(prs_phase == PH_HUNT && c != CH_STD && c != CH_EXT)) begin
            taken_chars++;
        end
        parse_char(c, got, f);
        if (got && !row_typed) begin
            pending_frames.push_back(f);
        end
    endtask

    function automatic logic [7:0] digit_char();
        logic [7:0] c;
        logic [3:0] v;
        if ($urandom_range(0, 99) < 2) begin
            do c = 8'($urandom_range(0, 255)); while (is_hex_char(c));
            return c;
        end
        v = 4'($urandom_range(0, 15));
        if (v < 10) begin
            return CH_ZERO + v;
        end
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 8'd10;
    endfunction

    task automatic send_random_frame();
        logic [7:0] c;
        logic [3:0] n_bytes;
        int         id_digits;
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_STD || c == CH_EXT) begin
                    c = CH_CR;
                end
                send_char(c);
            end
        end
        id_digits = $urandom_range(0, 1) ? EXT_ID_DIGITS : STD_ID_DIGITS;
        send_char(id_digits == EXT_ID_DIGITS ? CH_EXT : CH_STD);
        for (int k = 0; k < id_digits; k++) begin
            send_char(digit_char());
        end
        // drop the rest of the frame now and then
        if ($urandom_range(0, 99) < 3) begin
            return;
        end
        if ($urandom_range(0, 99) < 5) begin
            do c = 8'($urandom_range(0, 255)); while (c >= CH_ZERO && c <= CH_ZERO + MAX_BYTES);
            send_char(c);
            return;
        end
        n_bytes = 4'($urandom_range(0, MAX_BYTES));
        send_char(CH_ZERO + n_bytes);
        for (int k = 0; k < 2 * n_bytes; k++) begin
            send_char(digit_char());
        end
        if ($urandom_range(0, 99) < 2) begin
            return;
        end
        for (int k = 0; k < stamp_len; k++) begin
            send_char(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 5) begin
            do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
            send_char(c);
        end else begin
            send_char(CH_CR);
        end
    endtask

    // Close any open frame, drain, then write the register
    task automatic set_stamp(input logic [3:0] n);
        while (prs_phase != PH_HUNT) begin
            send_char(CH_CR);
        end
        char_bus.valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= n;
        @(negedge clk);
        cfg_we    <= 1'b0;
        stamp_len  = n;
    endtask

    initial begin : receiver
        frame_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                frame_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            frame_bus.ready <= !(idle_on && $urandom_range(0, 99) < 10);
        end
    end

    initial begin : frame_check
        frame_t want;
        forever begin
            @(posedge clk);
            if (rst_n && frame_bus.valid && frame_bus.ready) begin
                if (pending_frames.size() == 0) begin
                    report_mismatch($sformatf("frame ident %h with nothing pending",
                                              frame_bus.frame_ident));
                end else begin
                    want = pending_frames.pop_front();
                    compare_field("frame_extended", frame_bus.frame_extended, want.ext);
                    compare_field("frame_ident", frame_bus.frame_ident, want.ident);
                    compare_field("byte_count", frame_bus.byte_count, want.count);
                    compare_field("payload", frame_bus.payload, want.payload);
                    compare_field("status", frame_bus.status, want.status);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned goal;
        int          w;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        char_bus.valid   = 1'b0;
        char_bus.in_char = '0;
        mismatches       = 0;
        taken_chars      = 0;
        row_typed        = 1'b0;
        idle_on          = 1'b1;
        hold_off_req     = 1'b0;
        stamp_len        = STAMP_RESET;
        prs_phase        = PH_HUNT;
        digit_count      = '0;
        frame_is_ext     = 1'b0;
        ident_shift      = '0;
        data_len         = '0;
        data_shift       = '0;
        saw_bad_hex      = 1'b0;
        stamp_plan       = '{4'd0, 4'd15, 4'd1, 4'd0, 4'd0, STAMP_RESET};
        stamp_plan[3]    = 4'($urandom_range(2, 14));
        stamp_plan[4]    = 4'($urandom_range(0, 15));

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        send_char(8'h00);
        foreach (script[r]) begin
            row_typed = script[r].typed;
            for (int k = 0; k < script[r].text.len(); k++) begin
                send_char(script[r].text[k]);
            end
            if (row_typed) begin
                pending_frames.push_back(script[r].want);
            end
        end
        row_typed = 1'b0;

        goal = taken_chars;
        for (int p = 0; p < 6; p++) begin
            set_stamp(stamp_plan[p]);
            idle_on = (p != 2);
            // hold the receiver off while words keep coming
            if (p == 1) begin
                hold_off_req = 1'b1;
            end
            goal += PHASE_ITEMS;
            while (taken_chars < goal) begin
                send_random_frame();
            end
        end
        char_bus.valid <= 1'b0;

        for (w = 0; w < DRAIN_LIMIT && pending_frames.size() != 0; w++) begin
            @(posedge clk);
        end
        if (pending_frames.size() != 0) begin
            report_mismatch($sformatf("%0d frames never delivered", pending_frames.size()));
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ascd_pkg.sv
hw/rtl/ascd_ifs.sv
hw/rtl/ascd_in_stage.sv
hw/rtl/ascd_parser.sv
hw/rtl/ascii_can_frame_deframer.sv
bench/ascii_can_frame_deframer_test.sv
